// ----- rtl/tdf_pkg.sv -----
`default_nettype none

package tdf_pkg;

  // fixed widths of the channel payloads
  localparam int IN_WIDTH        = 32;
  localparam int FACTOR_WIDTH    = 32;
  localparam int STATUS_WIDTH    = 2;
  localparam int VALUE_WIDTH_DEF = 32;

  // result status codes
  localparam logic [STATUS_WIDTH-1:0] ST_FACTOR = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_ONE    = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_ZERO   = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TWOS,
    S_SQCHK,
    S_DIVIDE,
    S_DIVEVAL,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic                    load;
    logic                    push_special;
    logic [STATUS_WIDTH-1:0] special_code;
    logic                    shift_two;
    logic                    init_odd;
    logic                    init_div;
    logic                    div_step;
    logic                    take_quotient;
    logic                    next_divisor;
    logic                    take_rest;
    logic                    push_last;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rest_zero;
    logic rest_one;
    logic rest_even;
    logic rest_gt_two;
    logic sq_le_rest;
    logic div_last;
    logic rem_zero;
    logic out_free;
    logic pend_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tdf_in_if.sv -----
`default_nettype none

interface tdf_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdf_pkg::IN_WIDTH-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/tdf_out_if.sv -----
`default_nettype none

interface tdf_out_if;
  logic                              valid;
  logic                              ready;
  logic [tdf_pkg::FACTOR_WIDTH-1:0]  factor;
  logic                              last;
  logic [tdf_pkg::STATUS_WIDTH-1:0]  status;

  modport source (output valid, output factor, output last, output status, input ready);
  modport sink   (input valid, input factor, input last, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/tdf_datapath.sv -----
`default_nettype none

module tdf_datapath #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tdf_pkg::IN_WIDTH-1:0]      value,
  input  tdf_pkg::dp_cmd_t                  cmd,
  output tdf_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdf_pkg::FACTOR_WIDTH-1:0]  factor,
  output logic                              last,
  output logic [tdf_pkg::STATUS_WIDTH-1:0]  status
);
  import tdf_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int SW = VALUE_WIDTH + 2;
  localparam int CW = $clog2(VALUE_WIDTH);

  logic [W-1:0]  rest;
  logic [W-1:0]  divisor;
  logic [SW-1:0] dsq;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;
  logic [W-1:0]  pend;
  logic          pend_valid;

  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          ge;
  logic          push_pend;
  logic          push_any;

  // one restoring division step
  assign shifted = {rem, quo[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~diff[W+1];

  // pending factor goes out when a newer one replaces it
  assign push_pend = (cmd.shift_two | cmd.take_quotient | cmd.take_rest) & pend_valid;
  assign push_any  = push_pend | cmd.push_last | cmd.push_special;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      factor <= cmd.push_special ? '0 : FACTOR_WIDTH'(pend);
      last   <= cmd.push_last | cmd.push_special;
      status <= cmd.push_special ? cmd.special_code : ST_FACTOR;
    end
  end

  // remaining value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest <= W'(value);
    end else if (cmd.shift_two) begin
      rest <= rest >> 1;
    end else if (cmd.take_quotient) begin
      rest <= quo;
    end else if (cmd.take_rest) begin
      rest <= W'(1);
    end
  end

  // pending factor, held until it is known whether it is the final one
  always_ff @(posedge clk) begin
    if (cmd.shift_two) begin
      pend <= W'(2);
    end else if (cmd.take_quotient) begin
      pend <= divisor;
    end else if (cmd.take_rest) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load || cmd.push_last) begin
      pend_valid <= 1'b0;
    end else if (cmd.shift_two || cmd.take_quotient || cmd.take_rest) begin
      pend_valid <= 1'b1;
    end
  end

  // odd trial divisor and its square, stepped by (d+2)^2 = d^2 + 4d + 4
  always_ff @(posedge clk) begin
    if (cmd.init_odd) begin
      divisor <= W'(3);
      dsq     <= SW'(9);
    end else if (cmd.next_divisor) begin
      divisor <= divisor + W'(2);
      dsq     <= dsq + {divisor, 2'b00} + SW'(4);
    end
  end

  // serial divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.init_div) begin
      rem <= '0;
      quo <= rest;
      cnt <= CW'(W - 1);
    end else if (cmd.div_step) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  // status to controller
  always_comb begin
    stat.rest_zero   = (rest == '0);
    stat.rest_one    = (rest == W'(1));
    stat.rest_even   = ~rest[0];
    stat.rest_gt_two = (rest > W'(2));
    stat.sq_le_rest  = (dsq <= {2'b00, rest});
    stat.div_last    = (cnt == '0);
    stat.rem_zero    = (rem == '0);
    stat.out_free    = ~out_valid | out_ready;
    stat.pend_valid  = pend_valid;
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push_any && out_valid) |-> out_ready)
    else $error("result overwritten while stalled");

  // status-only results carry no factor and close the transaction group
  a_special_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FACTOR) |-> (factor == '0 && last))
    else $error("status-only result malformed");

  // a closing result with a factor always comes from a held factor
  a_last_has_factor: assert property (@(posedge clk) disable iff (rst)
    cmd.push_last |-> pend_valid)
    else $error("final result pushed with no pending factor");

endmodule

`default_nettype wire

// ----- rtl/tdf_controller.sv -----
`default_nettype none

module tdf_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdf_pkg::dp_stat_t  stat,
  output tdf_pkg::dp_cmd_t   cmd
);
  import tdf_pkg::*;

  state_t state;
  state_t state_next;
  logic   room;

  // a new factor may replace the pending one only if the output can take it
  assign room = ~stat.pend_valid | stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if (stat.rest_zero || stat.rest_one) begin
          if (stat.out_free) state_next = S_IDLE;
        end else begin
          state_next = S_TWOS;
        end
      end
      S_TWOS: begin
        if (!stat.rest_even) state_next = S_SQCHK;
      end
      S_SQCHK: begin
        state_next = stat.sq_le_rest ? S_DIVIDE : S_FINISH;
      end
      S_DIVIDE: begin
        if (stat.div_last) state_next = S_DIVEVAL;
      end
      S_DIVEVAL: begin
        if (!stat.rem_zero || room) state_next = S_SQCHK;
      end
      S_FINISH: begin
        if (!stat.rest_gt_two && stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        if (stat.rest_zero || stat.rest_one) begin
          cmd.push_special = stat.out_free;
          cmd.special_code = stat.rest_zero ? ST_ZERO : ST_ONE;
        end
      end
      S_TWOS: begin
        if (stat.rest_even) begin
          cmd.shift_two = room;
        end else begin
          cmd.init_odd = 1'b1;
        end
      end
      S_SQCHK: begin
        cmd.init_div = stat.sq_le_rest;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      S_DIVEVAL: begin
        if (stat.rem_zero) begin
          cmd.take_quotient = room;
        end else begin
          cmd.next_divisor = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.rest_gt_two) begin
          cmd.take_rest = room;
        end else begin
          cmd.push_last = stat.out_free;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/trial_division_factorizer_core.sv -----
`default_nettype none

// channel    dir   payload                       handshake
// operand    in    value[31:0]                   valid/ready
// result     out   factor[31:0], last, status    valid/ready
//
// one value is taken when the controller is idle; results leave in ascending order
// factors of two are removed first, then the value is trial divided by each odd divisor
// worst case about 2^(VALUE_WIDTH/2-1) odd divisors are tried
// the serial divider produces one quotient bit per cycle
// reset is synchronous and clears the controller and the output valid
// a stalled result holds the datapath only when a further result is ready to leave

module trial_division_factorizer_core #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tdf_in_if.sink     operand,
  tdf_out_if.source  result
);
  import tdf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  tdf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operand.valid),
    .in_ready (operand.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // divider, divisor stepping and output register
  tdf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (operand.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .factor    (result.factor),
    .last      (result.last),
    .status    (result.status)
  );

endmodule

`default_nettype wire
